// File: design/serial_rtc_eeprom_interface_defines.svh
// assertion macros used by the checker file
`ifndef SERIAL_RTC_EEPROM_INTERFACE_DEFINES_SVH
`define SERIAL_RTC_EEPROM_INTERFACE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sre check failed");

// next-cycle implication, sampled on clk, off during reset
`define SRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sre check failed");

`endif

// File: design/sre_pkg.sv
// shared types and constants of the serial rtc and eeprom front end
package sre_pkg;

    typedef enum logic [5:0] {
        MODE_CMD_WAIT     = 6'b000001,
        MODE_RTC_WRITE    = 6'b000010,
        MODE_EEPROM_WRITE = 6'b000100,
        MODE_WRITE_ENABLE = 6'b001000,
        MODE_RTC_READ     = 6'b010000,
        MODE_EEPROM_READ  = 6'b100000
    } mode_t;

    localparam logic [3:0] CMD_RTC_WRITE    = 4'h0;
    localparam logic [3:0] CMD_EEPROM_WRITE = 4'h2;
    localparam logic [3:0] CMD_WRITE_ENABLE = 4'h6;
    localparam logic [3:0] CMD_RTC_READ     = 4'h8;
    localparam logic [3:0] CMD_EEPROM_READ  = 4'hA;

    localparam logic [4:0] CMD_BITS          = 5'd4;
    localparam logic [4:0] RTC_ADDR_BITS     = 5'd4;
    localparam logic [4:0] RTC_FRAME_BITS    = 5'd12;
    localparam logic [4:0] EEPROM_ADDR_BITS  = 5'd12;
    localparam logic [4:0] EEPROM_FRAME_BITS = 5'd28;
    localparam logic [4:0] RTC_READ_BITS     = 5'd8;
    localparam logic [4:0] EEPROM_READ_BITS  = 5'd16;

    localparam logic [2:0]  RTC_FIXED_ADDR = 3'd7;
    localparam logic [7:0]  RTC_FIXED_BYTE = 8'h20;
    localparam logic [15:0] EEPROM_BLANK   = 16'hffff;

    typedef struct packed {
        logic        en;
        logic [7:0]  idx;
        logic [15:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
    } mem_rd_t;

    typedef struct packed {
        logic        active;
        logic [3:0]  sel;
        logic        from_mem;
        logic [15:0] data;
    } pend_t;

endpackage

// File: design/sre_in_if.sv
// input channel: sampled serial lines and current time
interface sre_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  line_bits;
    logic [55:0] time_now_bcd;

    modport source (output valid, output line_bits, output time_now_bcd, input ready);
    modport sink (input valid, input line_bits, input time_now_bcd, output ready);
endinterface

// File: design/sre_out_if.sv
// output channel: serial read bit
interface sre_out_if;
    logic valid;
    logic ready;
    logic data_out;

    modport source (output valid, output data_out, input ready);
    modport sink (input valid, input data_out, output ready);
endinterface

// File: design/sre_frame.sv
// serial frame decoder: command, address and data shifting per rising edge of the serial clock line
module sre_frame (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [2:0]      line_bits,
    input  logic [55:0]     time_now_bcd,
    output sre_pkg::mem_wr_t wr,
    output sre_pkg::mem_rd_t rd,
    output sre_pkg::pend_t   pend
);
    import sre_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic [8:0]  addr_reg, addr_next;
    logic [15:0] data_reg, data_next;
    logic [4:0]  rbi_reg, rbi_next;
    logic        from_mem_reg, from_mem_next;
    logic        clk_prev_reg;
    logic        rst_prev_reg;

    always_comb
    begin
        logic [4:0] bc_inc;
        logic       do_clear;
        mode_t      start_mode;
        logic [2:0] rtc_addr;
        logic [7:0] rtc_byte;
        logic       bit_in;

        mode_next      = mode_reg;
        bit_count_next = bit_count_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        rbi_next       = rbi_reg;
        from_mem_next  = from_mem_reg;
        wr             = '0;
        rd             = '0;
        do_clear       = 1'b0;
        start_mode     = MODE_CMD_WAIT;
        bc_inc         = bit_count_reg + 5'd1;
        bit_in         = line_bits[0];
        rtc_addr       = '0;
        rtc_byte       = '0;

        if (line_bits[2])
        begin
            do_clear = 1'b1;
        end
        else if (!rst_prev_reg && !clk_prev_reg && line_bits[1])
        begin
            unique case (mode_reg)
                MODE_CMD_WAIT:
                begin
                    cmd_next       = {cmd_reg[2:0], bit_in};
                    bit_count_next = bc_inc;
                    if (bc_inc == CMD_BITS)
                    begin
                        do_clear = 1'b1;
                        unique case (cmd_next)
                            CMD_RTC_WRITE:    start_mode = MODE_RTC_WRITE;
                            CMD_EEPROM_WRITE: start_mode = MODE_EEPROM_WRITE;
                            CMD_WRITE_ENABLE: start_mode = MODE_WRITE_ENABLE;
                            CMD_RTC_READ:     start_mode = MODE_RTC_READ;
                            CMD_EEPROM_READ:  start_mode = MODE_EEPROM_READ;
                            default:          start_mode = MODE_CMD_WAIT;
                        endcase
                    end
                end
                MODE_WRITE_ENABLE:
                begin
                    bit_count_next = bc_inc;
                    if (bc_inc >= RTC_FRAME_BITS)
                    begin
                        do_clear = 1'b1;
                    end
                end
                MODE_RTC_WRITE:
                begin
                    // time registers are reloaded on every read, so a write has no visible effect
                    bit_count_next = bc_inc;
                    if (bc_inc <= RTC_ADDR_BITS)
                    begin
                        addr_next = {addr_reg[7:0], bit_in};
                    end
                    else
                    begin
                        data_next = {data_reg[14:0], bit_in};
                    end
                    if (bc_inc >= RTC_FRAME_BITS)
                    begin
                        do_clear = 1'b1;
                    end
                end
                MODE_RTC_READ:
                begin
                    bit_count_next = bc_inc;
                    if (bc_inc <= RTC_ADDR_BITS)
                    begin
                        addr_next = {addr_reg[7:0], bit_in};
                        if (bc_inc == RTC_ADDR_BITS)
                        begin
                            rtc_addr = addr_next[2:0];
                            if (rtc_addr == RTC_FIXED_ADDR)
                            begin
                                rtc_byte = RTC_FIXED_BYTE;
                            end
                            else
                            begin
                                rtc_byte = time_now_bcd[{rtc_addr, 3'b000} +: 8];
                            end
                            data_next     = {8'h00, rtc_byte};
                            rbi_next      = RTC_READ_BITS;
                            from_mem_next = 1'b0;
                        end
                    end
                    else if (rbi_reg != 5'd0)
                    begin
                        rbi_next = rbi_reg - 5'd1;
                    end
                    if (bc_inc >= RTC_FRAME_BITS)
                    begin
                        bit_count_next = 5'd0;
                    end
                end
                MODE_EEPROM_WRITE:
                begin
                    bit_count_next = bc_inc;
                    if (bc_inc <= EEPROM_ADDR_BITS)
                    begin
                        addr_next = {addr_reg[7:0], bit_in};
                    end
                    else
                    begin
                        data_next = {data_reg[14:0], bit_in};
                    end
                    if (bc_inc >= EEPROM_FRAME_BITS)
                    begin
                        wr.en    = 1'b1;
                        wr.idx   = addr_next[8:1];
                        wr.data  = data_next;
                        do_clear = 1'b1;
                    end
                end
                MODE_EEPROM_READ:
                begin
                    bit_count_next = bc_inc;
                    if (bc_inc <= EEPROM_ADDR_BITS)
                    begin
                        addr_next = {addr_reg[7:0], bit_in};
                        if (bc_inc == EEPROM_ADDR_BITS)
                        begin
                            rd.en         = 1'b1;
                            rd.idx        = addr_next[8:1];
                            rbi_next      = EEPROM_READ_BITS;
                            from_mem_next = 1'b1;
                        end
                    end
                    else if (rbi_reg != 5'd0)
                    begin
                        rbi_next = rbi_reg - 5'd1;
                    end
                    if (bc_inc >= EEPROM_FRAME_BITS)
                    begin
                        bit_count_next = 5'd0;
                    end
                end
                default:
                begin
                    do_clear = 1'b1;
                end
            endcase
        end

        if (do_clear)
        begin
            mode_next      = start_mode;
            bit_count_next = '0;
            cmd_next       = '0;
            addr_next      = '0;
            data_next      = '0;
            rbi_next       = '0;
            from_mem_next  = 1'b0;
            wr.en          = wr.en;
        end

        if (!accept)
        begin
            wr.en = 1'b0;
            rd.en = 1'b0;
        end

        pend.active   = ((mode_next == MODE_RTC_READ) || (mode_next == MODE_EEPROM_READ))
                        && (rbi_next != 5'd0);
        pend.sel      = 4'(rbi_next - 5'd1);
        pend.from_mem = from_mem_next;
        pend.data     = data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CMD_WAIT;
            bit_count_reg <= '0;
            cmd_reg       <= '0;
            addr_reg      <= '0;
            data_reg      <= '0;
            rbi_reg       <= '0;
            from_mem_reg  <= 1'b0;
            clk_prev_reg  <= 1'b0;
            rst_prev_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            bit_count_reg <= bit_count_next;
            cmd_reg       <= cmd_next;
            addr_reg      <= addr_next;
            data_reg      <= data_next;
            rbi_reg       <= rbi_next;
            from_mem_reg  <= from_mem_next;
            clk_prev_reg  <= line_bits[1];
            rst_prev_reg  <= line_bits[2];
        end
    end

endmodule

// File: design/sre_eeprom.sv
// eeprom word store with per-word valid bits and registered read
module sre_eeprom #(
    parameter int WORDS = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sre_pkg::mem_wr_t wr,
    input  sre_pkg::mem_rd_t rd,
    output logic [15:0]      word
);
    import sre_pkg::*;

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [15:0]      mem [WORDS];
    logic [WORDS-1:0] valid_reg;
    logic [15:0]      rd_data_reg;
    logic             rd_ok_reg;
    logic             wr_in_range;
    logic             rd_in_range;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign wr_in_range = {1'b0, wr.idx} < 9'(WORDS);
    assign rd_in_range = {1'b0, rd.idx} < 9'(WORDS);
    assign wr_addr     = wr.idx[AW-1:0];
    assign rd_addr     = rd.idx[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_in_range)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr_in_range)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_ok_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    assign word = rd_ok_reg ? rd_data_reg : EEPROM_BLANK;

endmodule

// File: design/sre_out.sv
// bit select stage and result register with flow control
module sre_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_accept,
    input  sre_pkg::pend_t pend,
    input  logic [15:0]    word,
    input  logic           out_ready,
    output logic           in_ready,
    output logic           out_valid,
    output logic           data_out
);
    import sre_pkg::*;

    pend_t       s1_reg;
    logic        s1_valid_reg;
    logic        out_valid_reg;
    logic        data_out_reg;
    logic        advance;
    logic [15:0] src;
    logic        bit_next;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign src      = s1_reg.from_mem ? word : s1_reg.data;
    assign bit_next = s1_reg.active & src[s1_reg.sel];

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= pend;
        end
        if (advance && s1_valid_reg)
        begin
            data_out_reg <= bit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

endmodule

// File: design/serial_rtc_eeprom_interface.sv
// three-wire serial front end for a calendar clock and a word eeprom
// in_ch carries one sample of the serial lines (data, clock, stream reset)
// plus the current calendar time as packed bcd; out_ch returns one item per
// input item, the serial read bit seen after that sample.
// an accepted item is registered in the bit select stage, and its bit is
// loaded into the result register when out_ch does not stall; the eeprom
// read port is registered and feeds that same result stage.
// throughput: one item per cycle while out_ch takes each result; a stall
// on out_ch holds the flow through in_ch.ready.
// reset (rst_n low): stream state clears, previous line levels read low,
// all eeprom words read back as 0xffff until written.
// when out_ch stalls, one pending item and one result are held; in_ch.ready
// drops only when both are occupied and the result is not taken.
// eeprom writes and the read address take word index address[8:1];
// indexes at or above EEPROM_WORDS ignore writes and read 0xffff.
module serial_rtc_eeprom_interface #(
    parameter int EEPROM_WORDS = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    sre_in_if.sink   in_ch,
    sre_out_if.source out_ch
);
    import sre_pkg::*;

    logic        in_accept;
    logic        in_ready;
    mem_wr_t     wr;
    mem_rd_t     rd;
    pend_t       pend;
    logic [15:0] word;

    assign in_accept   = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    sre_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .line_bits    (in_ch.line_bits),
        .time_now_bcd (in_ch.time_now_bcd),
        .wr           (wr),
        .rd           (rd),
        .pend         (pend)
    );

    sre_eeprom #(
        .WORDS (EEPROM_WORDS)
    ) u_eeprom (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .word  (word)
    );

    sre_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .pend      (pend),
        .word      (word),
        .out_ready (out_ch.ready),
        .in_ready  (in_ready),
        .out_valid (out_ch.valid),
        .data_out  (out_ch.data_out)
    );

endmodule

// File: design/sre_checker.sv
// port-level checks for the serial rtc and eeprom front end
`include "serial_rtc_eeprom_interface_defines.svh"

module sre_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] line_bits,
    input logic       out_valid,
    input logic       out_ready,
    input logic       data_out
);
    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // held result keeps its bit
    `SRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data_out))
    // an empty result register never blocks the input
    `SRE_ASSERT_IMPLY(a_ready_when_empty, !out_valid, in_ready)
    // a fresh result stems from an accepted item, via the bit select stage
    `SRE_ASSERT_IMPLY(a_result_source, $rose(out_valid), $past(in_acc, 2))
    // a sample with stream reset high yields a zero bit
    `SRE_ASSERT_NEXT(a_reset_zero, in_acc && line_bits[2] ##1 (!out_valid || out_ready), out_valid && !data_out)

endmodule

bind serial_rtc_eeprom_interface sre_checker u_sre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .line_bits (in_ch.line_bits),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .data_out  (out_ch.data_out)
);
